// File: hw/rtl/sha1_digest_engine_unit_defines.svh
// Assertion macros used by the engine's sequencer (sha1de_ctrl).
`ifndef SHA1_DIGEST_ENGINE_UNIT_DEFINES_SVH
`define SHA1_DIGEST_ENGINE_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SHA1DE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define SHA1DE_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hw/rtl/sha1de_pkg.sv
package sha1de_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int CHAIN_WORDS = 5;
   localparam int ROUND_W     = 7;
   localparam int POS_W       = 6;
   localparam int LEN_W       = 64;

   typedef logic [WORD_W-1:0]  sha1de_word_type;
   typedef logic [ROUND_W-1:0] sha1de_round_type;
   typedef logic [POS_W-1:0]   sha1de_pos_type;

   localparam sha1de_round_type LAST_ROUND  = 7'd79;
   localparam sha1de_round_type ROUND_SEG1  = 7'd20;
   localparam sha1de_round_type ROUND_SEG2  = 7'd40;
   localparam sha1de_round_type ROUND_SEG3  = 7'd60;

   localparam sha1de_pos_type POS_LAST      = 6'd63;
   localparam sha1de_pos_type POS_LEN_START = 6'd56;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;
   localparam logic [LEN_W-1:0] BYTE_BITS = 64'd8;

   localparam sha1de_word_type K_SEG0 = 32'h5A827999;
   localparam sha1de_word_type K_SEG1 = 32'h6ED9EBA1;
   localparam sha1de_word_type K_SEG2 = 32'h8F1BBCDC;
   localparam sha1de_word_type K_SEG3 = 32'hCA62C1D6;

   localparam sha1de_word_type CHAIN_IV [CHAIN_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_FINISH
   } sha1de_state_type;

   // Sequencer commands to the datapath.
   typedef struct packed {
      logic put;   // absorb one byte
      logic push;  // byte completes a word: shift it into the schedule
      logic load;  // byte completes a block: copy chain into a..e
      logic step;  // run one round
      logic fold;  // add a..e into the chain
      logic init;  // restore the initial chain
      logic emit;  // capture the digest into the result register
   } sha1de_ctl_type;

   function automatic sha1de_word_type round_mix(sha1de_round_type t, sha1de_word_type b,
                                                 sha1de_word_type c, sha1de_word_type d);
      sha1de_word_type f;
      if (t < ROUND_SEG1) begin
         f = (b & c) | (~b & d);
      end else if (t < ROUND_SEG2) begin
         f = b ^ c ^ d;
      end else if (t < ROUND_SEG3) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic sha1de_word_type round_k(sha1de_round_type t);
      sha1de_word_type k;
      if (t < ROUND_SEG1) begin
         k = K_SEG0;
      end else if (t < ROUND_SEG2) begin
         k = K_SEG1;
      end else if (t < ROUND_SEG3) begin
         k = K_SEG2;
      end else begin
         k = K_SEG3;
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/sha1de_sched.sv
// Byte packer and 16-word message schedule window.
module sha1de_sched
   import sha1de_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sha1de_ctl_type  ctl,
   input  logic [7:0]      put_byte,
   output sha1de_word_type w_t
);

   logic [23:0]     part_ff;
   logic [23:0]     part_in;
   sha1de_word_type win_ff [BLOCK_WORDS];
   sha1de_word_type win_in [BLOCK_WORDS];
   sha1de_word_type expand;

   // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
   always_comb begin
      sha1de_word_type x;
      x = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      expand = {x[WORD_W-2:0], x[WORD_W-1]};
   end

   always_comb begin
      part_in = part_ff;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.put) begin
         part_in = {part_ff[15:0], put_byte};
      end
      if (ctl.push || ctl.step) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[BLOCK_WORDS-1] = ctl.push ? {part_ff, put_byte} : expand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
      end else begin
         part_ff <= part_in;
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   assign w_t = win_ff[0];

endmodule

// File: hw/rtl/sha1de_round.sv
// Shared round unit: working variables a..e and the chaining words.
module sha1de_round
   import sha1de_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  sha1de_ctl_type                 ctl,
   input  sha1de_round_type               round_idx,
   input  sha1de_word_type                w_t,
   output logic [CHAIN_WORDS*WORD_W-1:0]  chain
);

   sha1de_word_type var_ff   [CHAIN_WORDS];
   sha1de_word_type var_in   [CHAIN_WORDS];
   sha1de_word_type chain_ff [CHAIN_WORDS];
   sha1de_word_type chain_in [CHAIN_WORDS];
   sha1de_word_type temp;

   always_comb begin
      temp = {var_ff[0][WORD_W-6:0], var_ff[0][WORD_W-1:WORD_W-5]}
           + round_mix(round_idx, var_ff[1], var_ff[2], var_ff[3])
           + var_ff[4] + w_t + round_k(round_idx);
   end

   always_comb begin
      for (int k = 0; k < CHAIN_WORDS; k++) begin
         var_in[k]   = var_ff[k];
         chain_in[k] = chain_ff[k];
      end
      if (ctl.load) begin
         for (int k = 0; k < CHAIN_WORDS; k++) begin
            var_in[k] = chain_ff[k];
         end
      end else if (ctl.step) begin
         var_in[4] = var_ff[3];
         var_in[3] = var_ff[2];
         var_in[2] = {var_ff[1][1:0], var_ff[1][WORD_W-1:2]};
         var_in[1] = var_ff[0];
         var_in[0] = temp;
      end
      if (ctl.fold) begin
         for (int k = 0; k < CHAIN_WORDS; k++) begin
            chain_in[k] = chain_ff[k] + var_ff[k];
         end
      end else if (ctl.init) begin
         for (int k = 0; k < CHAIN_WORDS; k++) begin
            chain_in[k] = CHAIN_IV[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CHAIN_WORDS; k++) begin
         var_ff[k] <= var_in[k];
      end
      if (reset) begin
         for (int k = 0; k < CHAIN_WORDS; k++) begin
            chain_ff[k] <= CHAIN_IV[k];
         end
      end else begin
         for (int k = 0; k < CHAIN_WORDS; k++) begin
            chain_ff[k] <= chain_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CHAIN_WORDS; k++) begin
         chain[k*WORD_W +: WORD_W] = chain_ff[k];
      end
   end

endmodule

// File: hw/rtl/sha1de_ctrl.sv
`include "sha1_digest_engine_unit_defines.svh"

// Sequencer: byte intake, padding, round counting, length tracking.
module sha1de_ctrl
   import sha1de_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_byte,
   input  logic             req_has,
   input  logic             req_last,
   input  logic             out_free,
   output logic             req_ready,
   output sha1de_ctl_type   ctl,
   output logic [7:0]       put_byte,
   output sha1de_round_type round_idx
);

   sha1de_state_type st_ff, st_in;
   sha1de_state_type ret_ff, ret_in;
   sha1de_pos_type   pos_ff;
   sha1de_round_type round_ff;
   logic [LEN_W-1:0] len_ff;
   logic             accept;

   assign accept = req_valid && (st_ff == ST_IDLE);

   // Next state
   always_comb begin
      st_in  = st_ff;
      ret_in = ret_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_has && (pos_ff == POS_LAST)) begin
                  st_in  = ST_COMPRESS;
                  ret_in = req_last ? ST_PAD_MARK : ST_IDLE;
               end else if (req_last) begin
                  st_in = ST_PAD_MARK;
               end
            end
         end
         ST_COMPRESS: begin
            if (round_ff == LAST_ROUND) begin
               st_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            st_in = ret_ff;
         end
         ST_PAD_MARK: begin
            st_in = ST_PAD_ZERO;
            if (pos_ff == POS_LAST) begin
               st_in  = ST_COMPRESS;
               ret_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (pos_ff == POS_LEN_START) begin
               st_in = ST_PAD_LEN;
            end else if (pos_ff == POS_LAST) begin
               st_in  = ST_COMPRESS;
               ret_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            if (pos_ff == POS_LAST) begin
               st_in  = ST_COMPRESS;
               ret_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctl       = '0;
      put_byte  = PAD_ZERO_BYTE;
      req_ready = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.put   = req_valid && req_has;
            put_byte  = req_byte;
         end
         ST_COMPRESS: begin
            ctl.step = 1'b1;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
         end
         ST_PAD_MARK: begin
            ctl.put  = 1'b1;
            put_byte = PAD_MARK_BYTE;
         end
         ST_PAD_ZERO: begin
            ctl.put = (pos_ff != POS_LEN_START);
         end
         ST_PAD_LEN: begin
            ctl.put  = 1'b1;
            put_byte = len_ff[LEN_W-1 -: 8];
         end
         ST_FINISH: begin
            ctl.emit = out_free;
            ctl.init = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
      ctl.push = ctl.put && (pos_ff[1:0] == 2'b11);
      ctl.load = ctl.put && (pos_ff == POS_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         pos_ff   <= '0;
         round_ff <= '0;
         len_ff   <= '0;
      end else begin
         st_ff  <= st_in;
         ret_ff <= ret_in;
         if (ctl.put) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (ctl.step) begin
            round_ff <= (round_ff == LAST_ROUND) ? '0 : round_ff + 1'b1;
         end
         if (accept && req_has) begin
            len_ff <= len_ff + BYTE_BITS;
         end else if (st_ff == ST_PAD_LEN) begin
            len_ff <= {len_ff[LEN_W-9:0], 8'h00};
         end else if (ctl.emit) begin
            len_ff <= '0;
         end
      end
   end

   assign round_idx = round_ff;

   `SHA1DE_ASSERT(a_compress_aligned, st_ff == ST_COMPRESS |-> pos_ff == 6'd0, "rounds running off a block boundary")
   `SHA1DE_ASSERT(a_fold_after_last, st_ff == ST_FOLD |-> $past(round_ff) == LAST_ROUND, "fold without 80 rounds")
   `SHA1DE_ASSERT(a_len_closes, st_ff == ST_PAD_LEN && pos_ff == POS_LAST |=> st_ff == ST_COMPRESS && ret_ff == ST_FINISH, "length bytes did not close the final block")
   `SHA1DE_NEVER(a_put_and_step, ctl.put && (ctl.step || ctl.fold), "byte taken while the round unit is busy")

endmodule

// File: hw/rtl/sha1_digest_engine_unit.sv
// SHA-1 digest engine. Send a message one byte per req transaction: tdata carries the byte,
// tuser says whether the byte belongs to the message, tlast marks the end of the message
// (send tuser = 0 with tlast = 1 to hash an empty message, or to close a message whose last
// byte was already sent). A transaction with tuser = 0 and tlast = 0 does nothing. req_tready
// is high while the engine is idle; the byte that fills a 64-byte block holds it low
// while the single round unit runs the 80 rounds and adds the result into the chain. After
// tlast the engine pads the message itself (0x80, zeros up to byte 56, then the 64-bit bit
// length), which closes one or two more blocks. The digest leaves as one rsp transaction and
// sits in its own register, so the next message may start while it waits to be taken; a
// second digest waits until the first is gone. Bit length wraps modulo 2^64.
module sha1_digest_engine_unit
   import sha1de_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   // Message byte stream
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] data_byte
   input  logic           req_tuser,   // [0] has_byte
   input  logic           req_tlast,   // last_item
   // Digest stream
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [159:0]   rsp_tdata    // [31:0] digest_word_0, [63:32] digest_word_1,
                                       // [95:64] digest_word_2, [127:96] digest_word_3,
                                       // [159:128] digest_word_4
);

   sha1de_ctl_type   ctl;
   logic [7:0]       put_byte;
   sha1de_round_type round_idx;
   sha1de_word_type  w_t;
   logic [CHAIN_WORDS*WORD_W-1:0] chain;
   logic [CHAIN_WORDS*WORD_W-1:0] digest_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   // The result register can take a new digest once it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   sha1de_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_byte  (req_tdata),
      .req_has   (req_tuser),
      .req_last  (req_tlast),
      .out_free  (out_free),
      .req_ready (req_tready),
      .ctl       (ctl),
      .put_byte  (put_byte),
      .round_idx (round_idx)
   );

   // Pack bytes into words and expand the schedule one word per round.
   sha1de_sched u_sched (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .put_byte (put_byte),
      .w_t      (w_t)
   );

   // One round per cycle, then fold into the chaining words.
   sha1de_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .round_idx (round_idx),
      .w_t       (w_t),
      .chain     (chain)
   );

   // Hold the digest until the rsp transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         digest_ff <= chain;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = digest_ff;

endmodule

// File: dv/sha1_digest_engine_unit_test.sv
module sha1_digest_engine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sha1de_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int ITEM_TARGET    = 1300;
   localparam int MESSAGE_TARGET = 40;
   localparam int CALM_ITEMS     = 150;   // tail of the stream runs without idling
   localparam int HOLD_OFF       = 2000;  // long receiver stall to back up the engine
   localparam int HOLD_AFTER     = 3;     // digests taken before the long stall
   localparam int DRAIN_CYCLES   = 300;   // worst padding latency plus margin
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_item;
   } msg_item_type;

   typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] digest_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] data_byte
   logic         req_tuser = 1'b0;    // [0] has_byte
   logic         req_tlast = 1'b0;    // last_item
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;           // [31:0] digest_word_0 ... [159:128] digest_word_4

   // Stimulus and scoreboard
   msg_item_type byte_items[$];
   digest_type   expected_digests[$];
   msg_item_type on_bus;
   int        messages_queued;
   int        digests_taken = 0;
   int        fail_count = 0;
   int        send_gap;
   int        send_idle_pct;
   int        send_accepts;
   int        recv_stall;
   int        recv_idle_pct;
   int        recv_cycles;
   int        hold_cycles;
   bit        pressure_done = 1'b0;
   logic      calm_phase = 1'b0;
   int        quiet_cycles;

   // Shadow hash state
   sha1de_word_type msg_block [BLOCK_WORDS];
   sha1de_word_type chain     [CHAIN_WORDS];
   logic [LEN_W-1:0] msg_bits;
   sha1de_pos_type   fill_pos;

   sha1_digest_engine_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow SHA-1
   // ---------------------------------------------------------------

   // Restore the initial chain and clear the length and fill pointer.
   function automatic void restart_hash();
      for (int i = 0; i < CHAIN_WORDS; i++) chain[i] = CHAIN_IV[i];
      for (int i = 0; i < BLOCK_WORDS; i++) msg_block[i] = '0;
      msg_bits = '0;
      fill_pos = '0;
   endfunction

   // Run the 80 rounds over the full block and add into the chain.
   function automatic void compress_block();
      sha1de_word_type w [80];
      sha1de_word_type a, b, c, d, e, f, k, t_sum, x;
      for (int t = 0; t < 16; t++) w[t] = msg_block[t];
      for (int t = 16; t < 80; t++) begin
         x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
         w[t] = {x[30:0], x[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K_SEG0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K_SEG1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_SEG2;
         end else begin
            f = b ^ c ^ d;
            k = K_SEG3;
         end
         t_sum = {a[26:0], a[31:27]} + f + e + w[t] + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t_sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // Place one byte big-endian into the block; compress when it fills.
   function automatic void absorb_byte(logic [7:0] value);
      int shift;
      shift = 8 * (3 - int'(fill_pos[1:0]));
      msg_block[fill_pos[5:2]][shift +: 8] = value;
      fill_pos = fill_pos + 1'b1;
      if (fill_pos == '0) compress_block();
   endfunction

   // Apply one transaction; return 1 with the digest when it ends a message.
   function automatic bit hash_item(msg_item_type item, output digest_type digest);
      logic [LEN_W-1:0] len;
      digest = '0;
      if (item.has_byte) begin
         absorb_byte(item.data_byte);
         msg_bits += BYTE_BITS;
      end
      if (!item.last_item) return 1'b0;
      len = msg_bits;
      absorb_byte(PAD_MARK_BYTE);
      while (fill_pos != POS_LEN_START) absorb_byte(PAD_ZERO_BYTE);
      for (int i = 7; i >= 0; i--) absorb_byte(len[8*i +: 8]);
      for (int i = 0; i < CHAIN_WORDS; i++) digest[i] = chain[i];
      restart_hash();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------

   function automatic void push_item(logic [7:0] data_byte, logic has_byte, logic last_item);
      msg_item_type item;
      item.data_byte = data_byte;
      item.has_byte  = has_byte;
      item.last_item = last_item;
      byte_items.insert(byte_items.size(), item);
   endfunction

   // Queue one message of len bytes with random content. Sprinkle no-op
   // transactions, and close either on the last byte or with a separate
   // empty closing transaction.
   function automatic void queue_message(int len);
      bit close_on_byte;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 6) push_item(8'($urandom), 1'b0, 1'b0);
         push_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte) push_item(8'($urandom), 1'b0, 1'b1);
      messages_queued++;
   endfunction

   // Mostly short messages; a share sits on the padding boundaries where
   // the length field spills into a second block.
   function automatic int pick_length();
      int boundary [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) return $urandom_range(0, 20);
      if (pick <= 7) return boundary[$urandom_range(0, 7)];
      if (pick == 8) return $urandom_range(21, 130);
      return 0;
   endfunction

   // ---------------------------------------------------------------
   // Driver: offer queued items, idle in random bursts
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      digest_type digest;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         send_idle_pct = 10;
         send_accepts = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (hash_item(on_bus, digest)) begin
               expected_digests.insert(expected_digests.size(), digest);
            end
            send_accepts++;
            // Reshuffle the idle density so some stretches run back to back.
            if (send_accepts % 64 == 0) begin
               case ($urandom_range(0, 2))
                  0: send_idle_pct = 0;
                  1: send_idle_pct = 8;
                  default: send_idle_pct = 25;
               endcase
            end
         end
         calm_phase <= (byte_items.size() < CALM_ITEMS);
         // Hold the current item until it is taken.
         if (!req_tvalid || req_tready) begin
            if (byte_items.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = byte_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= on_bus.data_byte;
               req_tuser  <= on_bus.has_byte;
               req_tlast  <= on_bus.last_item;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check each digest transaction and drive backpressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      digest_type want;
      logic [WORD_W-1:0] got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         recv_idle_pct = 10;
         recv_cycles = 0;
         hold_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digests.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("[%0t] digest with no message pending: %h", $realtime, rsp_tdata);
            end else begin
               want = expected_digests.pop_front();
               for (int i = 0; i < CHAIN_WORDS; i++) begin
                  got = rsp_tdata[WORD_W*i +: WORD_W];
                  if (got !== want[i]) begin
                     fail_count++;
                     if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] digest %0d word %0d: expected %h, got %h",
                                 $realtime, digests_taken, i, want[i], got);
                  end
               end
            end
            digests_taken++;
         end

         recv_cycles++;
         if (recv_cycles % 200 == 0) begin
            case ($urandom_range(0, 2))
               0: recv_idle_pct = 0;
               1: recv_idle_pct = 8;
               default: recv_idle_pct = 30;
            endcase
         end

         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (!pressure_done && digests_taken >= HOLD_AFTER) begin
            // Stall the receiver long enough for a second digest to back up
            // behind the first and block the input side.
            pressure_done = 1'b1;
            hold_cycles = HOLD_OFF - 1;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_stall = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: end the run if neither side moves a transaction for too long
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence: build the stream, release reset, drain, report
   // ---------------------------------------------------------------
   initial begin
      restart_hash();
      messages_queued = 0;

      // Empty message.
      push_item(8'h5C, 1'b0, 1'b1);
      messages_queued++;
      // "abc" closed on its last byte.
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'h63, 1'b1, 1'b1);
      messages_queued++;
      // Extreme bytes with no-op transactions between, closed by an empty item.
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b1);
      messages_queued++;
      // Single-byte message closed on the byte.
      push_item(8'hFF, 1'b1, 1'b1);
      messages_queued++;
      // Two empty messages back to back.
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'hA5, 1'b0, 1'b1);
      messages_queued += 2;

      // Random messages until both the item and message counts are reached.
      while (byte_items.size() < ITEM_TARGET || messages_queued < MESSAGE_TARGET)
         queue_message(pick_length());

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is taken and every digest is checked.
      do begin
         @(posedge clock);
      end while (byte_items.size() != 0 || req_tvalid || expected_digests.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_digests.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
